/* rtl/pts_pkg.sv */
// shared constants and controller/datapath interface types for the task scheduler
package pts_pkg;

  localparam int MaxTasksDef = 8;
  localparam int ModeW       = 2;
  localparam int PeriodW     = 16;
  localparam int SlotW       = 3;
  localparam int ResCap      = 8;
  localparam int ResCntW     = $clog2(ResCap + 1);

  localparam logic [ModeW-1:0] MODE_REG  = 2'd0;
  localparam logic [ModeW-1:0] MODE_TICK = 2'd1;
  localparam logic [ModeW-1:0] MODE_DISP = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_TASK  = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic capture;
    logic do_reg;
    logic do_tick;
    logic do_disp;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

/* rtl/periodic_task_scheduler_top.sv */
// Periodic task scheduler: a table of up to MAX_TASKS slots with reload period,
// down counter and pending flag. in_tuser selects register (0), tick (1) or
// dispatch (2); mode 3 is ignored. One transaction is worked on at a time and
// the slot table is walked one slot per cycle through a single read port
// (a dispatch holds while a pending slot waits on out_tready): register waits
// only for the output register, a tick visits all task_count slots, and a
// dispatch walks them in order and stops early once eight results are out.
// Registration answers with one reply; dispatch emits up to eight pending
// slots in slot order, tlast on the final one, and nothing when none is pending.
module periodic_task_scheduler_top #(
  parameter int MAX_TASKS = pts_pkg::MaxTasksDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // period[15:0]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // accepted[0], slot[3:1], zero fill[7:4]
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast
);

  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_period  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_reg, cmd.do_tick, cmd.do_disp}))
    else $error("more than one datapath command active");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.do_reg || cmd.do_tick || cmd.do_disp))
    else $error("datapath command while accepting input");

  a_task_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == pts_pkg::KIND_TASK)) |-> (out_tdata[0] == 1'b0))
    else $error("dispatch result with accepted set");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == pts_pkg::KIND_REPLY)) |-> out_tlast)
    else $error("registration reply without tlast");
`endif

endmodule

/* rtl/pts_datapath.sv */
// slot table, walk index and output register of the task scheduler
module pts_datapath #(
  parameter int MAX_TASKS = pts_pkg::MaxTasksDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pts_pkg::PeriodW-1:0] in_period,
  input  pts_pkg::cmd_t              cmd,
  output pts_pkg::sts_t              sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  localparam int CntW = $clog2(MAX_TASKS + 1);
  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [CntW-1:0]                 count_r;
  logic [CntW-1:0]                 idx_r;
  logic [pts_pkg::ResCntW-1:0]     nres_r;
  logic [pts_pkg::PeriodW-1:0]     period_r;
  logic [pts_pkg::PeriodW-1:0]     reload_mem [MAX_TASKS];
  logic [pts_pkg::PeriodW-1:0]     down_mem   [MAX_TASKS];
  logic [MAX_TASKS-1:0]            pend_r;

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic                            out_acc_r;
  logic [pts_pkg::SlotW-1:0]       out_slot_r;
  logic                            out_last_r;

  logic [IdxW-1:0]                 cur;
  logic                            walk_end;
  logic                            out_free;
  logic                            pend_above;
  logic                            reject;
  logic                            reg_fire;
  logic                            tick_fire;
  logic                            disp_emit;
  logic                            disp_skip;

  always_comb begin
    cur        = idx_r[IdxW-1:0];
    walk_end   = (idx_r >= count_r) || (nres_r == pts_pkg::ResCntW'(pts_pkg::ResCap));
    out_free   = !out_valid_r || out_tready;
    reject     = (period_r == '0) || (count_r == CntW'(MAX_TASKS));
    reg_fire   = cmd.do_reg && out_free;
    tick_fire  = cmd.do_tick && !walk_end;
    disp_emit  = cmd.do_disp && !walk_end && pend_r[cur] && out_free;
    disp_skip  = cmd.do_disp && !walk_end && !pend_r[cur];
    // any occupied slot beyond the current one still pending
    pend_above = 1'b0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (pend_r[j] && (CntW'(j) > idx_r) && (CntW'(j) < count_r)) begin
        pend_above = 1'b1;
      end
    end
  end

  assign sts.walk_end = walk_end;
  assign sts.out_free = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r  <= '0;
        nres_r <= '0;
      end else if (tick_fire || disp_skip) begin
        idx_r <= idx_r + CntW'(1);
      end else if (disp_emit) begin
        idx_r  <= idx_r + CntW'(1);
        nres_r <= nres_r + pts_pkg::ResCntW'(1);
      end
      if (reg_fire && !reject) begin
        count_r <= count_r + CntW'(1);
      end
      if (reg_fire || disp_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slot table and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      period_r <= in_period;
    end
    if (reg_fire) begin
      out_kind_r <= pts_pkg::KIND_REPLY;
      out_acc_r  <= !reject;
      out_slot_r <= reject ? '0 : pts_pkg::SlotW'(count_r);
      out_last_r <= 1'b1;
      if (!reject) begin
        reload_mem[count_r[IdxW-1:0]] <= period_r;
        down_mem[count_r[IdxW-1:0]]   <= period_r;
        pend_r[count_r[IdxW-1:0]]     <= 1'b0;
      end
    end
    if (tick_fire && (down_mem[cur] != '0)) begin
      // reaching zero reloads and marks the slot pending
      if (down_mem[cur] == pts_pkg::PeriodW'(1)) begin
        down_mem[cur] <= reload_mem[cur];
        pend_r[cur]   <= 1'b1;
      end else begin
        down_mem[cur] <= down_mem[cur] - pts_pkg::PeriodW'(1);
      end
    end
    if (disp_emit) begin
      pend_r[cur] <= 1'b0;
      out_kind_r  <= pts_pkg::KIND_TASK;
      out_acc_r   <= 1'b0;
      out_slot_r  <= pts_pkg::SlotW'(idx_r);
      out_last_r  <= !pend_above ||
                     (nres_r == pts_pkg::ResCntW'(pts_pkg::ResCap - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_slot_r, out_acc_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/pts_ctrl.sv */
// controller state machine of the task scheduler
module pts_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic [pts_pkg::ModeW-1:0] in_mode,
  output logic                     in_tready,
  input  pts_pkg::sts_t            sts,
  output pts_pkg::cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REG,
    ST_TICK,
    ST_DISP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.capture = accept;
    cmd.do_reg  = (state_r == ST_REG);
    cmd.do_tick = (state_r == ST_TICK);
    cmd.do_disp = (state_r == ST_DISP);
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            pts_pkg::MODE_REG:  state_nxt = ST_REG;
            pts_pkg::MODE_TICK: state_nxt = ST_TICK;
            pts_pkg::MODE_DISP: state_nxt = ST_DISP;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REG: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK, ST_DISP: begin
        if (sts.walk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
